// ===== sv/csvt_pkg.sv =====
`timescale 1ns / 1ps

package csvt_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_STATUS    = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_FIELD_LARGE  = 4'd1;
    localparam logic [3:0] ST_MANY_COLUMNS = 4'd2;
    localparam logic [3:0] ST_MANY_RECORDS = 4'd3;
    localparam logic [3:0] ST_SPACE_AFTER  = 4'd4;
    localparam logic [3:0] ST_TEXT_AFTER   = 4'd5;
    localparam logic [3:0] ST_QUOTE_INSIDE = 4'd6;
    localparam logic [3:0] ST_UNCLOSED     = 4'd7;
    localparam logic [3:0] ST_NO_HEADER    = 4'd8;

    // configuration register indexes
    localparam int unsigned CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_MAX_FIELD_BYTES = 2'd0;
    localparam logic [CFG_IW-1:0] REG_MAX_COLUMNS     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_MAX_RECORDS     = 2'd2;
    localparam int unsigned CFG_DW = 24;

    // register reset values
    localparam logic [15:0] RST_MAX_FIELD_BYTES = 16'd4096;
    localparam logic [15:0] RST_MAX_COLUMNS     = 16'd256;
    localparam logic [23:0] RST_MAX_RECORDS     = 24'd100000;

    // saturation limits of the counters
    localparam logic [16:0] LEN_MAX = 17'h1FFFF;
    localparam logic [24:0] ROW_MAX = 25'h1FFFFFF;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // result queue
    localparam int unsigned FIFO_DEPTH = 4;

    // output tdata width: 8 + 1 + 16 + 25 + 4 = 54, padded to 56
    localparam int unsigned OUT_DW = 56;

    typedef struct packed {
        logic [15:0] field_bytes_lim;
        logic [15:0] columns_lim;
        logic [23:0] records_lim;
    } limits_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  data_byte;
        logic        row_end;
        logic [15:0] column_index;
        logic [24:0] row_index;
        logic [3:0]  status_code;
        logic        last;
    } result_t;

    function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] data,
                                          input logic rend, input logic [15:0] col,
                                          input logic [24:0] row, input logic [3:0] status);
        result_t r;
        r.out_kind     = kind;
        r.data_byte    = data;
        r.row_end      = rend;
        r.column_index = col;
        r.row_index    = row;
        r.status_code  = status;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_status(input logic [3:0] status);
        return mk_result(KIND_STATUS, 8'd0, 1'b0, 16'd0, 25'd0, status);
    endfunction

endpackage

// ===== sv/csv_stream_tokenizer_top.sv =====
`timescale 1ns / 1ps
// path: an accepted input transaction waits in the input register until the result queue
//   has room for two results, and its results then leave on m_* from the head of the queue
// throughput: one input transaction per cycle while the four-entry result queue has room
//   for two results, else s_tready stalls; both results of an item share the single m_* port
// reset: rst_n clears the tokenizer state, the queue and the input register at once and
//   loads the limits with their defaults (4096 bytes, 256 columns, 100000 records)

module csv_stream_tokenizer_top
    import csvt_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,

    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,     // [7:0] text_byte
    input  logic              s_tuser,     // [0] kind (0 text byte, 1 end of input)

    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,     // [7:0] data_byte, [8] row_end,
                                           // [24:9] column_index, [49:25] row_index,
                                           // [53:50] status_code, [55:54] zero
    output logic [1:0]        m_tuser,     // [1:0] out_kind
    output logic              m_tlast,     // last result of one input transaction

    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int unsigned CW = $clog2(DEPTH) + 1;

    // input register
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;

    // limits written through the configuration port
    limits_t    lim_reg;

    logic       advance;
    result_t    res0;
    result_t    res1;
    logic [1:0] res_cnt;
    result_t    head;
    logic       q_not_empty;
    logic [CW-1:0] q_count;

    // the input register moves on only when the queue has room for two results
    assign advance  = in_valid_reg && (q_count <= CW'(DEPTH - 2));
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // configuration register decode; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lim_reg.field_bytes_lim <= RST_MAX_FIELD_BYTES;
            lim_reg.columns_lim     <= RST_MAX_COLUMNS;
            lim_reg.records_lim     <= RST_MAX_RECORDS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAX_FIELD_BYTES: lim_reg.field_bytes_lim <= cfg_data[15:0];
                REG_MAX_COLUMNS:     lim_reg.columns_lim     <= cfg_data[15:0];
                REG_MAX_RECORDS:     lim_reg.records_lim     <= cfg_data[23:0];
                default:             ;
            endcase
        end
    end

    // tokenizer step: mode, counters, limit checks; up to two results per transaction
    csvt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_kind (in_kind_reg),
        .in_byte (in_byte_reg),
        .lim     (lim_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    // result queue decouples the two results of one item from the output handshake
    csvt_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .pop       (m_tready),
        .head      (head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign m_tvalid = q_not_empty;
    assign m_tuser  = head.out_kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {2'b00, head.status_code, head.row_index, head.column_index,
                       head.row_end, head.data_byte};

    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(DEPTH))
        else $error("result queue overflow");

    // a step only fires with room for two results
    a_room_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt != 2'd0) |-> (q_count <= CW'(DEPTH - 2)))
        else $error("results pushed without room");

    // a status is always the final result of its transaction
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_STATUS) |-> m_tlast)
        else $error("status result not marked last");

    // an accepted item is taken into the tokenizer on the next cycle when the queue is empty
    a_input_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && q_count == '0) |-> advance)
        else $error("input register stalled with empty queue");

endmodule

// ===== sv/csvt_core.sv =====
`timescale 1ns / 1ps

module csvt_core
    import csvt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    in_kind,
    input  logic [7:0] in_byte,
    input  limits_t lim,
    output result_t res0,
    output result_t res1,
    output logic [1:0] res_cnt
);

    typedef enum logic [2:0] {
        MODE_UNQ = 3'b001,
        MODE_QUO = 3'b010,
        MODE_AFT = 3'b100
    } mode_t;

    typedef struct packed {
        logic [1:0]  cnt;
        result_t     r0;
        result_t     r1;
        logic [16:0] fl;
        logic [16:0] cc;
        logic [24:0] rc;
        logic        saw;
        logic [3:0]  err;
    } close_t;

    mode_t       mode_reg, mode_next;
    logic        skip_lf_reg, skip_lf_next;
    logic        saw_reg, saw_next;
    logic [16:0] fl_reg, fl_next;
    logic [16:0] cc_reg, cc_next;
    logic [24:0] rc_reg, rc_next;
    logic [3:0]  err_reg, err_next;

    logic [16:0] fl_inc;
    logic        do_close;
    logic        close_row;
    close_t      cl;
    result_t     r [2];
    logic [1:0]  cnt;

    function automatic close_t close_field(input logic ends_row, input logic [16:0] fl,
                                           input logic [16:0] cc, input logic [24:0] rc,
                                           input logic saw, input limits_t lm);
        close_t      c;
        logic [16:0] cnt1;
        logic [24:0] rc_inc;
        logic [24:0] rec_lim;
        c.cnt  = 2'd0;
        c.r0   = '0;
        c.r1   = '0;
        c.fl   = fl;
        c.cc   = cc;
        c.rc   = rc;
        c.saw  = saw;
        c.err  = ST_OK;
        cnt1    = (cc < LEN_MAX) ? cc + 17'd1 : LEN_MAX;
        rc_inc  = (rc < ROW_MAX) ? rc + 25'd1 : ROW_MAX;
        rec_lim = {1'b0, lm.records_lim} + 25'd1;
        if (fl > {1'b0, lm.field_bytes_lim}) begin
            c.cnt = 2'd1;
            c.r0  = mk_status(ST_FIELD_LARGE);
            c.err = ST_FIELD_LARGE;
        end else if (!ends_row) begin
            c.cc  = cnt1;
            c.fl  = '0;
            c.cnt = 2'd1;
            c.r0  = mk_result(KIND_FIELD_END, 8'd0, 1'b0, cc[15:0], rc, ST_OK);
            if (cnt1 >= {1'b0, lm.columns_lim}) begin
                c.cnt = 2'd2;
                c.r1  = mk_status(ST_MANY_COLUMNS);
                c.err = ST_MANY_COLUMNS;
            end
        end else if (cnt1 > {1'b0, lm.columns_lim}) begin
            c.cnt = 2'd1;
            c.r0  = mk_status(ST_MANY_COLUMNS);
            c.err = ST_MANY_COLUMNS;
        end else if (cnt1 == 17'd1 && fl == '0 && !saw) begin
            // blank line: dropped
            c.cc = '0;
        end else begin
            c.cnt = 2'd1;
            c.r0  = mk_result(KIND_FIELD_END, 8'd0, 1'b1, cc[15:0], rc, ST_OK);
            c.rc  = rc_inc;
            c.cc  = '0;
            c.fl  = '0;
            c.saw = 1'b0;
            if (rc_inc > rec_lim) begin
                c.cnt = 2'd2;
                c.r1  = mk_status(ST_MANY_RECORDS);
                c.err = ST_MANY_RECORDS;
            end
        end
        return c;
    endfunction

    assign fl_inc = (fl_reg < LEN_MAX) ? fl_reg + 17'd1 : fl_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        skip_lf_next = skip_lf_reg;
        saw_next     = saw_reg;
        fl_next      = fl_reg;
        cc_next      = cc_reg;
        rc_next      = rc_reg;
        err_next     = err_reg;
        do_close     = 1'b0;
        close_row    = 1'b0;
        cnt          = 2'd0;
        r[0]         = '0;
        r[1]         = '0;
        cl           = '0;

        if (in_kind) begin
            // end of input: close an open row unless a quote is still open, then the final status
            if (err_reg == ST_OK) begin
                if (mode_reg == MODE_QUO) begin
                    err_next = ST_UNCLOSED;
                end else if (mode_reg == MODE_AFT || fl_reg != '0 || cc_reg != '0) begin
                    do_close  = 1'b1;
                    close_row = 1'b1;
                end
            end
        end else if (err_reg == ST_OK) begin
            skip_lf_next = 1'b0;
            if (!(skip_lf_reg && in_byte == CH_LF)) begin
                unique case (mode_reg)
                    MODE_QUO:
                    begin
                        if (in_byte == CH_QUOTE) begin
                            mode_next = MODE_AFT;
                        end else begin
                            saw_next = 1'b1;
                            fl_next  = fl_inc;
                            cnt      = 2'd1;
                            if (fl_inc > {1'b0, lim.field_bytes_lim}) begin
                                r[0]     = mk_status(ST_FIELD_LARGE);
                                err_next = ST_FIELD_LARGE;
                            end else begin
                                r[0] = mk_result(KIND_DATA, in_byte, 1'b0, cc_reg[15:0],
                                                 rc_reg, ST_OK);
                            end
                        end
                    end
                    MODE_AFT:
                    begin
                        if (in_byte == CH_QUOTE) begin
                            // doubled quote: literal, length checked at field end
                            mode_next = MODE_QUO;
                            fl_next   = fl_inc;
                            cnt       = 2'd1;
                            r[0]      = mk_result(KIND_DATA, in_byte, 1'b0, cc_reg[15:0],
                                                  rc_reg, ST_OK);
                        end else if (in_byte == CH_COMMA) begin
                            mode_next = MODE_UNQ;
                            do_close  = 1'b1;
                        end else if (in_byte == CH_CR || in_byte == CH_LF) begin
                            mode_next    = MODE_UNQ;
                            skip_lf_next = (in_byte == CH_CR);
                            do_close     = 1'b1;
                            close_row    = 1'b1;
                        end else if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
                            cnt      = 2'd1;
                            r[0]     = mk_status(ST_SPACE_AFTER);
                            err_next = ST_SPACE_AFTER;
                        end else begin
                            cnt      = 2'd1;
                            r[0]     = mk_status(ST_TEXT_AFTER);
                            err_next = ST_TEXT_AFTER;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_UNQ;
                        if (in_byte == CH_QUOTE) begin
                            if (fl_reg != '0) begin
                                cnt      = 2'd1;
                                r[0]     = mk_status(ST_QUOTE_INSIDE);
                                err_next = ST_QUOTE_INSIDE;
                            end else begin
                                mode_next = MODE_QUO;
                                saw_next  = 1'b1;
                            end
                        end else if (in_byte == CH_COMMA) begin
                            do_close = 1'b1;
                        end else if (in_byte == CH_CR || in_byte == CH_LF) begin
                            skip_lf_next = (in_byte == CH_CR);
                            do_close     = 1'b1;
                            close_row    = 1'b1;
                        end else begin
                            saw_next = 1'b1;
                            fl_next  = fl_inc;
                            cnt      = 2'd1;
                            if (fl_inc > {1'b0, lim.field_bytes_lim}) begin
                                r[0]     = mk_status(ST_FIELD_LARGE);
                                err_next = ST_FIELD_LARGE;
                            end else begin
                                r[0] = mk_result(KIND_DATA, in_byte, 1'b0, cc_reg[15:0],
                                                 rc_reg, ST_OK);
                            end
                        end
                    end
                endcase
            end
        end

        if (do_close) begin
            cl       = close_field(close_row, fl_reg, cc_reg, rc_reg, saw_reg, lim);
            cnt      = cl.cnt;
            r[0]     = cl.r0;
            r[1]     = cl.r1;
            fl_next  = cl.fl;
            cc_next  = cl.cc;
            rc_next  = cl.rc;
            saw_next = cl.saw;
            err_next = cl.err;
        end

        if (in_kind) begin
            // a failing row close already carries the final status
            if (!(do_close && cl.err != ST_OK)) begin
                if (err_next == ST_OK && rc_next == '0) begin
                    err_next = ST_NO_HEADER;
                end
                r[cnt[0]] = mk_status(err_next);
                cnt       = cnt + 2'd1;
            end
            mode_next    = MODE_UNQ;
            skip_lf_next = 1'b0;
            saw_next     = 1'b0;
            fl_next      = '0;
            cc_next      = '0;
            rc_next      = '0;
            err_next     = ST_OK;
        end

        if (cnt == 2'd2) begin
            r[1].last = 1'b1;
        end else if (cnt == 2'd1) begin
            r[0].last = 1'b1;
        end
    end

    assign res0    = r[0];
    assign res1    = r[1];
    assign res_cnt = advance ? cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_UNQ;
            skip_lf_reg <= 1'b0;
            saw_reg     <= 1'b0;
            fl_reg      <= '0;
            cc_reg      <= '0;
            rc_reg      <= '0;
            err_reg     <= ST_OK;
        end else if (advance) begin
            mode_reg    <= mode_next;
            skip_lf_reg <= skip_lf_next;
            saw_reg     <= saw_next;
            fl_reg      <= fl_next;
            cc_reg      <= cc_next;
            rc_reg      <= rc_next;
            err_reg     <= err_next;
        end
    end

endmodule

// ===== sv/csvt_fifo.sv =====
`timescale 1ns / 1ps

module csvt_fifo
    import csvt_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic [1:0] push_cnt,
    input  result_t push0,
    input  result_t push1,
    input  logic    pop,
    output result_t head,
    output logic    not_empty,
    output logic [$clog2(DEPTH):0] count
);

    localparam int unsigned AW = $clog2(DEPTH);

    result_t        mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;
    logic [AW-1:0]  wr_ptr_p1;
    logic           do_pop;

    assign wr_ptr_p1 = wr_ptr_reg + AW'(1);
    assign do_pop    = pop && (count_reg != '0);

    // storage needs no reset
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_p1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push_cnt);
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + (AW+1)'(push_cnt) - (AW+1)'(do_pop);
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule
